@@ hdl/sti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

	// Field widths
	localparam int TRI_BITS      = 17;
	localparam int INDEX_BITS    = 16;
	localparam int CFG_BITS      = 8;
	localparam int CFG_ADDR_BITS = 2;
	localparam int QUO_BITS      = 8;

	// Register indexes
	localparam logic [CFG_ADDR_BITS-1:0] CFG_DIVISIONS = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_RINGS     = 2'd1;

	// Reset values
	localparam logic [CFG_BITS-1:0] DIVISIONS_RESET = 8'd8;
	localparam logic [CFG_BITS-1:0] RINGS_RESET     = 8'd4;

	typedef enum logic [1:0] {
		REGION_NONE,
		REGION_BOTTOM,
		REGION_BAND,
		REGION_TOP
	} region_t;

	// Sideband that rides along the divider stages
	typedef struct packed {
		region_t               region;
		logic                  odd;
		logic [CFG_BITS-1:0]   fan_pos;
		logic [INDEX_BITS-1:0] pole;
	} meta_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] rem;
		logic [QUO_BITS-1:0]   quo;
		meta_t                 meta;
	} div_stage_t;

	typedef struct packed {
		region_t               region;
		logic                  odd;
		logic [INDEX_BITS-1:0] lo;
		logic [INDEX_BITS-1:0] hi;
		logic [INDEX_BITS-1:0] base;
		logic [INDEX_BITS-1:0] pole;
		logic [CFG_BITS-1:0]   j;
		logic [CFG_BITS-1:0]   up_off;
		logic [CFG_BITS-1:0]   hi2_off;
		logic [CFG_BITS-1:0]   right_off;
		logic [CFG_BITS-1:0]   fan_pos;
		logic [CFG_BITS-1:0]   fan_next;
	} prep_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] first_index;
		logic [INDEX_BITS-1:0] second_index;
		logic [INDEX_BITS-1:0] third_index;
		logic                  valid_res;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/sti_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sti_cfg_if;
	import sti_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] index;
	logic [CFG_BITS-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/sti_tri_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sti_tri_if;
	import sti_pkg::*;

	logic                valid;
	logic                ready;
	logic [TRI_BITS-1:0] triangle_number;

	modport source (output valid, output triangle_number, input ready);
	modport sink (input valid, input triangle_number, output ready);
endinterface

`default_nettype wire

@@ hdl/sti_idx_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sti_idx_if;
	import sti_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] first_index;
	logic [INDEX_BITS-1:0] second_index;
	logic [INDEX_BITS-1:0] third_index;
	logic                  valid_res;

	modport source (output valid, output first_index, output second_index,
		output third_index, output valid_res, input ready);
	modport sink (input valid, input first_index, input second_index,
		input third_index, input valid_res, output ready);
endinterface

`default_nettype wire

@@ hdl/sphere_triangle_indices.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                           Handshake
// cfg       in   index, data (0 ring_divisions, 1 ring_count)      valid/ready
// triangle  in   triangle_number                                   valid/ready
// indices   out  first_index, second_index, third_index, valid_res valid/ready
//
// One request per cycle sustained while the indices channel is not stalled; 12 register
// stages lie between an accepted request and its result being offered.
// Depth is set by the 8-stage restoring divider by ring_divisions (one quotient
// bit per stage), plus request, classify, index-prep and output stages.
// Reset clears all stage valids and loads ring_divisions 8, ring_count 4.
// Each stage holds when the stage after it is full and stalled; empty stages fill.
// cfg is always ready.

module sphere_triangle_indices (
	input  wire        clk,
	input  wire        arst_n,
	sti_cfg_if.sink    cfg,
	sti_tri_if.sink    triangle,
	sti_idx_if.source  indices
);
	import sti_pkg::*;

	localparam int DIV_STAGES = QUO_BITS;

	// Configuration registers
	logic [CFG_BITS-1:0] div_q;
	logic [CFG_BITS-1:0] rings_q;

	// Stage 1: request and ring product
	logic                  v_s1;
	logic                  rdy_s1;
	logic [TRI_BITS-1:0]   t_s1;
	logic [INDEX_BITS-1:0] dr_s1;

	// Stage 2: classification
	logic                  v_s2;
	logic                  rdy_s2;
	logic [INDEX_BITS-1:0] p_s2;
	meta_t                 meta_s2;

	// Divider stages
	logic       div_v   [DIV_STAGES];
	logic       div_rdy [DIV_STAGES];
	div_stage_t div_s   [DIV_STAGES];

	// Index prep and output stages
	logic    v_s11;
	logic    rdy_s11;
	prep_t   prep_s11;
	logic    v_s12;
	logic    rdy_s12;
	result_t res_s12;

	// Combinational values
	logic [TRI_BITS-1:0]   total;
	logic [TRI_BITS-1:0]   top_start;
	logic [TRI_BITS-1:0]   m_val;
	logic [TRI_BITS-1:0]   k_val;
	region_t               region_c;
	logic [CFG_BITS:0]     d9;
	logic [CFG_BITS-1:0]   j_c;
	logic [CFG_BITS-1:0]   i_c;
	logic [CFG_BITS:0]     js;
	logic [CFG_BITS:0]     js1;
	logic [CFG_BITS:0]     j1;
	logic [CFG_BITS:0]     fan1;
	logic [INDEX_BITS-1:0] lo_c;
	prep_t                 prep_c;
	result_t               res_c;

	// Accept configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= DIVISIONS_RESET;
			rings_q <= RINGS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DIVISIONS: div_q   <= cfg.data;
				CFG_RINGS:     rings_q <= cfg.data;
				default:       ;
			endcase
		end
	end

	// Ready chain: a stage advances when empty or when its successor advances
	assign rdy_s12 = !v_s12 || indices.ready;
	assign rdy_s11 = !v_s11 || rdy_s12;
	assign div_rdy[DIV_STAGES-1] = !div_v[DIV_STAGES-1] || rdy_s11;
	genvar g;
	generate
		for (g = 0; g < DIV_STAGES - 1; g++) begin : g_rdy
			assign div_rdy[g] = !div_v[g] || div_rdy[g+1];
		end
	endgenerate
	assign rdy_s2 = !v_s2 || div_rdy[0];
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign triangle.ready = rdy_s1;

	// Stage 1: take request, form D*R
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy_s1) v_s1 <= triangle.valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			t_s1  <= triangle.triangle_number;
			dr_s1 <= INDEX_BITS'(div_q) * INDEX_BITS'(rings_q);
		end
	end

	// Stage 2: classify into bottom fan, band, top fan or out of range
	always_comb begin
		total     = {dr_s1, 1'b0};
		top_start = total - TRI_BITS'(div_q);
		m_val     = t_s1 - TRI_BITS'(div_q);
		k_val     = t_s1 - top_start;
		if (t_s1 >= total)
			region_c = REGION_NONE;
		else if (t_s1 < TRI_BITS'(div_q))
			region_c = REGION_BOTTOM;
		else if (t_s1 >= top_start)
			region_c = REGION_TOP;
		else
			region_c = REGION_BAND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			p_s2           <= m_val[TRI_BITS-1:1];
			meta_s2.region <= region_c;
			meta_s2.odd    <= m_val[0];
			meta_s2.fan_pos <= (region_c == REGION_TOP) ? k_val[CFG_BITS-1:0]
				: t_s1[CFG_BITS-1:0];
			meta_s2.pole   <= dr_s1;
		end
	end

	// Divider: one quotient bit per stage, most significant first
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_div
			localparam int SH = DIV_STAGES - 1 - g;
			div_stage_t            prev;
			logic                  prev_v;
			logic [INDEX_BITS-1:0] dsh;
			div_stage_t            next;

			if (g == 0) begin : g_first
				assign prev.rem  = p_s2;
				assign prev.quo  = '0;
				assign prev.meta = meta_s2;
				assign prev_v    = v_s2;
			end else begin : g_rest
				assign prev   = div_s[g-1];
				assign prev_v = div_v[g-1];
			end

			always_comb begin
				dsh  = INDEX_BITS'(div_q) << SH;
				next = prev;
				if (prev.rem >= dsh) begin
					next.rem     = prev.rem - dsh;
					next.quo[SH] = 1'b1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) div_v[g] <= 1'b0;
				else if (div_rdy[g]) div_v[g] <= prev_v;
			end

			always_ff @(posedge clk) begin
				if (div_rdy[g]) div_s[g] <= next;
			end
		end
	endgenerate

	// Stage 11: ring bases and wrapped offsets
	always_comb begin
		i_c  = div_s[DIV_STAGES-1].quo;
		j_c  = div_s[DIV_STAGES-1].rem[CFG_BITS-1:0];
		d9   = {1'b0, div_q};
		lo_c = INDEX_BITS'(i_c) * INDEX_BITS'(div_q);
		js   = {1'b0, j_c} + (CFG_BITS+1)'(i_c[0]);
		// step on from the already wrapped upper offset
		js1  = ((js == d9) ? '0 : js) + 1'b1;
		j1   = {1'b0, j_c} + 1'b1;
		fan1 = {1'b0, div_s[DIV_STAGES-1].meta.fan_pos} + 1'b1;

		prep_c.region    = div_s[DIV_STAGES-1].meta.region;
		prep_c.odd       = div_s[DIV_STAGES-1].meta.odd;
		prep_c.pole      = div_s[DIV_STAGES-1].meta.pole;
		prep_c.fan_pos   = div_s[DIV_STAGES-1].meta.fan_pos;
		prep_c.lo        = lo_c;
		prep_c.hi        = lo_c + INDEX_BITS'(div_q);
		prep_c.base      = div_s[DIV_STAGES-1].meta.pole - INDEX_BITS'(div_q);
		prep_c.j         = j_c;
		prep_c.up_off    = (js == d9) ? '0 : js[CFG_BITS-1:0];
		prep_c.hi2_off   = (js1 == d9) ? '0 : js1[CFG_BITS-1:0];
		prep_c.right_off = (j1 == d9) ? '0 : j1[CFG_BITS-1:0];
		prep_c.fan_next  = (fan1 == d9) ? '0 : fan1[CFG_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (rdy_s11) v_s11 <= div_v[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (rdy_s11) prep_s11 <= prep_c;
	end

	// Stage 12: pick the three indices for the region
	always_comb begin
		res_c = '0;
		case (prep_s11.region)
			REGION_BOTTOM: begin
				res_c.first_index  = prep_s11.pole;
				res_c.second_index = INDEX_BITS'(prep_s11.fan_pos);
				res_c.third_index  = INDEX_BITS'(prep_s11.fan_next);
				res_c.valid_res    = 1'b1;
			end
			REGION_TOP: begin
				res_c.first_index  = prep_s11.pole + 1'b1;
				res_c.second_index = prep_s11.base + INDEX_BITS'(prep_s11.fan_next);
				res_c.third_index  = prep_s11.base + INDEX_BITS'(prep_s11.fan_pos);
				res_c.valid_res    = 1'b1;
			end
			REGION_BAND: begin
				res_c.third_index = prep_s11.lo + INDEX_BITS'(prep_s11.right_off);
				res_c.valid_res   = 1'b1;
				if (prep_s11.odd) begin
					res_c.first_index  = prep_s11.hi + INDEX_BITS'(prep_s11.up_off);
					res_c.second_index = prep_s11.hi + INDEX_BITS'(prep_s11.hi2_off);
				end else begin
					res_c.first_index  = prep_s11.lo + INDEX_BITS'(prep_s11.j);
					res_c.second_index = prep_s11.hi + INDEX_BITS'(prep_s11.up_off);
				end
			end
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (rdy_s12) v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (rdy_s12) res_s12 <= res_c;
	end

	// Drive result channel
	assign indices.valid        = v_s12;
	assign indices.first_index  = res_s12.first_index;
	assign indices.second_index = res_s12.second_index;
	assign indices.third_index  = res_s12.third_index;
	assign indices.valid_res    = res_s12.valid_res;

`ifndef NO_ASSERTIONS
	// Band remainder ends below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_v[DIV_STAGES-1] && div_s[DIV_STAGES-1].meta.region == REGION_BAND
		|-> div_s[DIV_STAGES-1].rem < INDEX_BITS'(div_q))
		else $error("divider remainder not below ring_divisions");

	// Band ring number stays below the ring count
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_v[DIV_STAGES-1] && div_s[DIV_STAGES-1].meta.region == REGION_BAND
		|-> div_s[DIV_STAGES-1].quo < rings_q)
		else $error("band ring number out of range");

	// An accepted request occupies the first stage
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		triangle.valid && triangle.ready |=> v_s1)
		else $error("accepted request lost at stage 1");

	// A stalled prep stage keeps its item
	a_prep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 && !rdy_s11 |=> v_s11 && $stable(prep_s11))
		else $error("prep stage dropped a stalled item");
`endif

endmodule

`default_nettype wire

@@ verif/sti_index_checker.sv @@
`timescale 1ns / 1ps

module sti_index_checker (
	input  wire clk,
	input  wire arst_n,
	sti_cfg_if  cfg,
	sti_tri_if  triangle,
	sti_idx_if  indices,
	output int  mismatches,
	output int  outstanding
);
	import sti_pkg::*;

	logic [CFG_BITS-1:0] divisions;
	logic [CFG_BITS-1:0] rings;
	result_t             pending_corners[$];

	// Compute the three corners of one triangle under the current mesh shape
	function automatic result_t triangle_corners(input logic [TRI_BITS-1:0] number);
		int unsigned t, d, r, count, pole, top_start, k, base;
		int unsigned m, p, i, j, s, lo, hi, up, right;
		result_t     res;
		t = number;
		d = divisions;
		r = rings;
		count = 2 * d * r;
		res = '0;
		if (t < count) begin
			pole = d * r;
			top_start = d * (2 * r - 1);
			res.valid_res = 1'b1;
			if (t < d) begin
				// bottom fan around the lower pole
				res.first_index  = INDEX_BITS'(pole);
				res.second_index = INDEX_BITS'(t);
				res.third_index  = INDEX_BITS'((t + 1) % d);
			end else if (t >= top_start) begin
				// top fan around the upper pole
				k = t - top_start;
				base = d * (r - 1);
				res.first_index  = INDEX_BITS'(pole + 1);
				res.second_index = INDEX_BITS'(base + (k + 1) % d);
				res.third_index  = INDEX_BITS'(base + k);
			end else begin
				// band between ring i and ring i+1, upper ring staggered on odd i
				m = t - d;
				p = m >> 1;
				i = p / d;
				j = p % d;
				s = i & 1;
				lo = i * d;
				hi = (i + 1) * d;
				up = hi + (j + s) % d;
				right = lo + (j + 1) % d;
				if ((m & 1) == 0) begin
					res.first_index  = INDEX_BITS'(lo + j);
					res.second_index = INDEX_BITS'(up);
				end else begin
					res.first_index  = INDEX_BITS'(up);
					res.second_index = INDEX_BITS'(hi + (j + s + 1) % d);
				end
				res.third_index = INDEX_BITS'(right);
			end
		end
		return res;
	endfunction

	// Track the shape, queue predictions for requests, compare results in order
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			divisions = DIVISIONS_RESET;
			rings = RINGS_RESET;
			pending_corners.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DIVISIONS: divisions = cfg.data;
					CFG_RINGS:     rings = cfg.data;
					default:       ;
				endcase
			end
			if (triangle.valid && triangle.ready)
				pending_corners.push_back(triangle_corners(triangle.triangle_number));
			if (indices.valid && indices.ready) begin
				if (pending_corners.size() == 0) begin
					$error("result with no triangle request pending");
					mismatches++;
				end else begin
					want = pending_corners.pop_front();
					if (indices.first_index !== want.first_index) begin
						$error("first_index: expected %0d, actual %0d",
							want.first_index, indices.first_index);
						mismatches++;
					end
					if (indices.second_index !== want.second_index) begin
						$error("second_index: expected %0d, actual %0d",
							want.second_index, indices.second_index);
						mismatches++;
					end
					if (indices.third_index !== want.third_index) begin
						$error("third_index: expected %0d, actual %0d",
							want.third_index, indices.third_index);
						mismatches++;
					end
					if (indices.valid_res !== want.valid_res) begin
						$error("valid_res: expected %0d, actual %0d",
							want.valid_res, indices.valid_res);
						mismatches++;
					end
				end
			end
			outstanding = pending_corners.size();
		end
	end

endmodule

@@ verif/sphere_triangle_indices_tb.sv @@
`timescale 1ns / 1ps

module sphere_triangle_indices_tb;
	import sti_pkg::*;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_HI = 2'd3;
	localparam int PHASE_ITEMS      = 48;
	localparam int DRAIN_CYCLES     = 20;
	localparam int HOLD_OFF_CYCLES  = 80;
	localparam int TRIANGLE_MAX     = (1 << TRI_BITS) - 1;

	typedef enum int {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n;
	pace_t       pace = PACE_FULL;
	logic        hold_off_armed = 1'b0;
	int unsigned mesh_total;
	int          mismatches;
	int          outstanding;

	sti_cfg_if cfg_bus ();
	sti_tri_if triangle_bus ();
	sti_idx_if index_bus ();

	sphere_triangle_indices DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.triangle (triangle_bus),
		.indices  (index_bus)
	);

	sti_index_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_bus),
		.triangle    (triangle_bus),
		.indices     (index_bus),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Hold one request until the block takes it, with random gaps before it
	task automatic send_triangle(input logic [TRI_BITS-1:0] number);
		int gap_pct;
		gap_pct = (pace == PACE_SENDER_IDLE) ? 68 : (pace == PACE_BOTH) ? 16 : 0;
		while ($urandom_range(99) < gap_pct) begin
			triangle_bus.valid <= 1'b0;
			@(posedge clk);
		end
		triangle_bus.valid <= 1'b1;
		triangle_bus.triangle_number <= number;
		@(posedge clk);
		while (!triangle_bus.ready) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_ADDR_BITS-1:0] index,
		input logic [CFG_BITS-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	// Load a mesh shape; a write to an unused index goes first and must be ignored
	task automatic program_mesh(input logic [CFG_BITS-1:0] d, input logic [CFG_BITS-1:0] r);
		write_register($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
			CFG_BITS'($urandom_range(255)));
		write_register(CFG_DIVISIONS, d);
		write_register(CFG_RINGS, r);
		cfg_bus.valid <= 1'b0;
		mesh_total = 2 * d * r;
	endtask

	// Drop valid, let the checker see the last request, then let the pipeline empty out
	task automatic drain;
		triangle_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly in-range triangles, some just past the end, some anywhere
	function automatic logic [TRI_BITS-1:0] pick_triangle;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0 || mesh_total == 0)
			return TRI_BITS'($urandom_range(TRIANGLE_MAX));
		if (pick == 1)
			return TRI_BITS'(mesh_total + $urandom_range(3));
		return TRI_BITS'($urandom_range(mesh_total - 1));
	endfunction

	// Result side: random stalls per pace, plus one long hold-off
	initial begin
		int held;
		held = 0;
		index_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_armed && held < HOLD_OFF_CYCLES) begin
				held++;
				index_bus.ready <= 1'b0;
			end else begin
				case (pace)
					PACE_RECEIVER_STALL: index_bus.ready <= ($urandom_range(99) >= 68);
					PACE_BOTH:           index_bus.ready <= ($urandom_range(99) >= 16);
					default:             index_bus.ready <= 1'b1;
				endcase
			end
		end
	end

	// Stimulus: directed shapes first, then random phases
	initial begin
		int unsigned reset_shape[15] = '{0, 7, 8, 9, 23, 24, 25, 55, 56, 63, 64,
			131071, 65536, 43690, 87381};
		int unsigned tiny_shape[3] = '{0, 1, 2};
		int unsigned widest_shape[6] = '{254, 255, 256, 129795, 130049, 130050};

		arst_n = 1'b0;
		triangle_bus.valid <= 1'b0;
		triangle_bus.triangle_number <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_DIVISIONS;
		cfg_bus.data <= '0;
		mesh_total = 2 * DIVISIONS_RESET * RINGS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: both fans, both band parities, odd-ring stagger, out of range
		foreach (reset_shape[n]) send_triangle(TRI_BITS'(reset_shape[n]));
		drain();
		// One division, one ring: a pole fan each way and nothing else
		program_mesh(8'd1, 8'd1);
		foreach (tiny_shape[n]) send_triangle(TRI_BITS'(tiny_shape[n]));
		drain();
		// Widest mesh: largest indices and the last valid triangle
		program_mesh(8'd255, 8'd255);
		foreach (widest_shape[n]) send_triangle(TRI_BITS'(widest_shape[n]));
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0:       program_mesh(DIVISIONS_RESET, RINGS_RESET);
				2:       program_mesh(8'd1, 8'd1);
				3:       program_mesh(8'd255, 8'd255);
				4:       program_mesh(8'd0, CFG_BITS'($urandom_range(255, 1)));
				5:       program_mesh(CFG_BITS'($urandom_range(255, 1)), 8'd0);
				7:       program_mesh(CFG_BITS'($urandom_range(255, 1)),
					CFG_BITS'($urandom_range(255, 1)));
				default: program_mesh(CFG_BITS'($urandom_range(24, 1)),
					CFG_BITS'($urandom_range(12, 1)));
			endcase
			pace = pace_t'(phase % 4);
			hold_off_armed = (phase == 8);
			repeat (PHASE_ITEMS) send_triangle(pick_triangle());
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
hdl/sti_pkg.sv
hdl/sti_cfg_if.sv
hdl/sti_tri_if.sv
hdl/sti_idx_if.sv
hdl/sphere_triangle_indices.sv
verif/sti_index_checker.sv
verif/sphere_triangle_indices_tb.sv
